// ===== hdl/fcu_pkg.sv =====
// ----------------------------------------------------------------------------
// fcu_pkg
// Shared types, constants and command codes of the follow chain update block.
// ----------------------------------------------------------------------------
package fcu_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int POS_W  = 24;
    localparam int DIR_W  = 16;
    localparam int IDX_W  = 5;
    localparam int QF     = 14;
    localparam int QUOT_W = 15;
    localparam int RADW   = 18;
    localparam int VW     = (POS_W + 1 > 18) ? POS_W + 1 : 18;
    localparam int BTW    = 19;
    localparam int CFG_W  = 16;

    typedef enum logic [2:0] {
        CFG_SEGMENT_LIMIT = 3'd0,
        CFG_START_RADIUS  = 3'd1,
        CFG_RADIUS_STEP   = 3'd2,
        CFG_FOLLOW_MODE   = 3'd3,
        CFG_BIAS_X        = 3'd4,
        CFG_BIAS_Y        = 3'd5,
        CFG_BIAS_STRENGTH = 3'd6
    } cfg_reg_t;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_MOVE  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_UNPLACED = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [POS_W-1:0] head_x;
        logic signed [POS_W-1:0] head_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        seg_index;
        logic signed [POS_W-1:0] seg_x;
        logic signed [POS_W-1:0] seg_y;
        logic                    status;
        logic                    last;
    } result_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ERR,
        DP_PL_HEAD,
        DP_MV_HEAD,
        DP_LOAD_R0,
        DP_DIFF,
        DP_SQ,
        DP_SUM,
        DP_ROOT_GO,
        DP_ZERO,
        DP_DIV_GO,
        DP_QUOT,
        DP_BIAS,
        DP_MUL,
        DP_ADD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_place;
        logic placed;
        logic follow;
        logic seg0_last;
        logic seg_last;
        logic root_done;
        logic root_zero;
        logic div_done;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ERR,
        ST_P_HEAD,
        ST_M_HEAD,
        ST_M_R0,
        ST_DIFF,
        ST_SQ,
        ST_SUM,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BIAS,
        ST_MUL,
        ST_ADD,
        ST_RD
    } ctrl_state_t;

endpackage

// ===== hdl/fcu_sqrt.sv =====
// ----------------------------------------------------------------------------
// fcu_sqrt
// Iterative integer square root, two operand bits per cycle, floor result.
// ----------------------------------------------------------------------------
module fcu_sqrt #(
    parameter int RW = fcu_pkg::VW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] operand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int CNW = $clog2(RW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNW-1:0]  cnt_reg, cnt_next;
    logic [2*RW-1:0] op_reg, op_next;
    logic [RW:0]     rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RW+2:0]   rem_t;
    logic [RW+2:0]   trial;

    assign rem_t = {rem_reg, op_reg[2*RW-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNW'(RW);
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            op_next  = {op_reg[2*RW-3:0], 2'b00};
            cnt_next = cnt_reg - CNW'(1);
            if (rem_t >= trial)
            begin
                rem_next  = (RW+1)'(rem_t - trial);
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (RW+1)'(rem_t);
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== hdl/fcu_div.sv =====
// ----------------------------------------------------------------------------
// fcu_div
// Restoring unsigned divider, one quotient bit per cycle, quotient known short.
// ----------------------------------------------------------------------------
module fcu_div #(
    parameter int NW = fcu_pkg::VW + fcu_pkg::QF,
    parameter int DW = fcu_pkg::VW,
    parameter int QW = fcu_pkg::QUOT_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int CNW = $clog2(QW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  den_reg, den_next;
    logic [QW-1:0]  low_reg, low_next;
    logic [DW:0]    rem_t;
    logic           ge;

    assign rem_t = {rem_reg, low_reg[QW-1]};
    assign ge    = rem_t >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNW'(QW);
            rem_next  = DW'(num >> QW);
            den_next  = den;
            low_next  = num[QW-1:0];
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNW'(1);
            rem_next = ge ? DW'(rem_t - {1'b0, den_reg}) : DW'(rem_t);
            low_next = {low_reg[QW-2:0], ge};
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

// ===== hdl/fcu_datapath.sv =====
// ----------------------------------------------------------------------------
// fcu_datapath
// Registers, segment memories and arithmetic of the chain, driven by commands.
// ----------------------------------------------------------------------------
module fcu_datapath #(
    parameter int MAX_SEGMENTS = fcu_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [fcu_pkg::CFG_W-1:0] cfg_data,
    input  fcu_pkg::in_item_t    item,
    input  fcu_pkg::dp_cmd_t     cmd,
    output fcu_pkg::dp_status_t  stat,
    output logic                 result_valid,
    output fcu_pkg::result_t     result
);

    localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int PW   = fcu_pkg::POS_W;
    localparam int VW   = fcu_pkg::VW;
    localparam int QF   = fcu_pkg::QF;
    localparam int RADW = fcu_pkg::RADW;
    localparam int BTW  = fcu_pkg::BTW;
    localparam int QW   = fcu_pkg::QUOT_W;
    localparam int PRW  = VW + RADW + 1;
    localparam int BPW  = 2 * fcu_pkg::DIR_W + 1;
    localparam int NW   = VW + QF;

    // configuration
    logic [5:0]         seg_limit_reg;
    logic [14:0]        start_radius_reg;
    logic [14:0]        radius_step_reg;
    logic               follow_mode_reg;
    logic signed [15:0] bias_x_reg;
    logic signed [15:0] bias_y_reg;
    logic [15:0]        bias_strength_reg;

    // control
    logic [CW-1:0] count_reg, count_next;
    logic          placed_reg, placed_next;
    logic          res_valid_reg, res_valid_next;
    logic [IW-1:0] idx_reg, idx_next;

    // payload
    logic                   op_reg, op_next;
    logic [PW-1:0]          hx_reg, hx_next, hy_reg, hy_next;
    logic [PW-1:0]          prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [RADW-1:0] prev_r_reg, prev_r_next, cur_r_reg, cur_r_next;
    logic signed [VW-1:0]   vx_reg, vx_next, vy_reg, vy_next;
    logic [2*VW-1:0]        sqx_reg, sqx_next, sqy_reg, sqy_next, sum_reg, sum_next;
    logic signed [PRW-1:0]  prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic signed [BTW-1:0]  btx_reg, btx_next, bty_reg, bty_next;
    fcu_pkg::result_t       res_reg, res_next;

    // memories
    logic [PW-1:0]   mem_x [MAX_SEGMENTS];
    logic [PW-1:0]   mem_y [MAX_SEGMENTS];
    logic [RADW-1:0] mem_r [MAX_SEGMENTS];
    logic [PW-1:0]   rd_x_reg, rd_y_reg;
    logic [RADW-1:0] rd_r_reg;
    logic            pos_we, rad_we;
    logic [PW-1:0]   wr_x, wr_y;
    logic [RADW-1:0] wr_r;

    // arithmetic
    logic [CW-1:0]          n_seg;
    logic [CW-1:0]          idx_inc;
    logic signed [RADW-1:0] nr;
    logic signed [RADW:0]   reach;
    logic [PRW-1:0]         rnd_x, rnd_y;
    logic signed [PRW-1:0]  adj_x, adj_y;
    logic [PW-1:0]          new_x, new_y;
    logic signed [BPW-1:0]  bprod_x, bprod_y;
    logic [BPW-1:0]         brnd_x, brnd_y;
    logic signed [BPW-1:0]  badj_x, badj_y;
    logic signed [2*VW-1:0] sq_x, sq_y;
    logic [VW-1:0]          abs_x, abs_y;
    logic                   root_done, div_done_x, div_done_y;
    logic [VW-1:0]          root;
    logic [QW-1:0]          quot_x, quot_y;
    logic                   seg_last, seg0_last;

    always_comb
    begin
        if (seg_limit_reg == '0)
            n_seg = CW'(1);
        else if (int'(seg_limit_reg) > MAX_SEGMENTS)
            n_seg = CW'(MAX_SEGMENTS);
        else
            n_seg = CW'(seg_limit_reg);
    end

    assign idx_inc = CW'(idx_reg) + CW'(1);
    assign nr      = cur_r_reg - $signed({{(RADW-15){1'b0}}, radius_step_reg});
    assign reach   = (RADW+1)'(cur_r_reg) + (RADW+1)'(prev_r_reg);

    assign rnd_x = {{(PRW-QF){1'b0}}, {QF{prod_x_reg[PRW-1]}}};
    assign rnd_y = {{(PRW-QF){1'b0}}, {QF{prod_y_reg[PRW-1]}}};
    assign adj_x = prod_x_reg + $signed(rnd_x);
    assign adj_y = prod_y_reg + $signed(rnd_y);
    assign new_x = prev_x_reg + adj_x[QF+PW-1:QF];
    assign new_y = prev_y_reg + adj_y[QF+PW-1:QF];

    assign bprod_x = BPW'(bias_x_reg) * BPW'($signed({1'b0, bias_strength_reg}));
    assign bprod_y = BPW'(bias_y_reg) * BPW'($signed({1'b0, bias_strength_reg}));
    assign brnd_x  = {{(BPW-QF){1'b0}}, {QF{bprod_x[BPW-1]}}};
    assign brnd_y  = {{(BPW-QF){1'b0}}, {QF{bprod_y[BPW-1]}}};
    assign badj_x  = bprod_x + $signed(brnd_x);
    assign badj_y  = bprod_y + $signed(brnd_y);

    assign sq_x  = (2*VW)'(vx_reg) * (2*VW)'(vx_reg);
    assign sq_y  = (2*VW)'(vy_reg) * (2*VW)'(vy_reg);
    assign abs_x = vx_reg[VW-1] ? VW'(-vx_reg) : VW'(vx_reg);
    assign abs_y = vy_reg[VW-1] ? VW'(-vy_reg) : VW'(vy_reg);

    assign seg0_last = (op_reg == fcu_pkg::OP_PLACE) ? (n_seg == CW'(1))
                                                     : (count_reg == CW'(1));
    assign seg_last  = (op_reg == fcu_pkg::OP_PLACE)
                     ? ((idx_inc == n_seg) || nr[RADW-1] || (nr == '0))
                     : (idx_inc == count_reg);

    fcu_sqrt #(
        .RW(VW)
    ) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.op == fcu_pkg::DP_ROOT_GO),
        .operand(sum_reg),
        .done   (root_done),
        .root   (root)
    );

    fcu_div #(
        .NW(NW),
        .DW(VW),
        .QW(QW)
    ) u_div_x (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.op == fcu_pkg::DP_DIV_GO),
        .num  ({abs_x, {QF{1'b0}}}),
        .den  (root),
        .done (div_done_x),
        .quot (quot_x)
    );

    fcu_div #(
        .NW(NW),
        .DW(VW),
        .QW(QW)
    ) u_div_y (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.op == fcu_pkg::DP_DIV_GO),
        .num  ({abs_y, {QF{1'b0}}}),
        .den  (root),
        .done (div_done_y),
        .quot (quot_y)
    );

    always_comb
    begin
        stat.is_place  = (op_reg == fcu_pkg::OP_PLACE);
        stat.placed    = placed_reg;
        stat.follow    = follow_mode_reg;
        stat.seg0_last = seg0_last;
        stat.seg_last  = seg_last;
        stat.root_done = root_done;
        stat.root_zero = (root == '0);
        stat.div_done  = div_done_x & div_done_y;
    end

    always_comb
    begin
        count_next     = count_reg;
        placed_next    = placed_reg;
        res_valid_next = 1'b0;
        idx_next       = idx_reg;
        op_next        = op_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_r_next    = prev_r_reg;
        cur_r_next     = cur_r_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        sum_next       = sum_reg;
        prod_x_next    = prod_x_reg;
        prod_y_next    = prod_y_reg;
        btx_next       = btx_reg;
        bty_next       = bty_reg;
        res_next       = res_reg;
        pos_we         = 1'b0;
        rad_we         = 1'b0;
        wr_x           = hx_reg;
        wr_y           = hy_reg;
        wr_r           = RADW'(cur_r_reg);
        unique case (cmd.op) inside
            fcu_pkg::DP_LOAD:
            begin
                op_next  = item.opcode;
                hx_next  = item.head_x;
                hy_next  = item.head_y;
                vx_next  = VW'(item.dir_x);
                vy_next  = VW'(item.dir_y);
                idx_next = '0;
            end
            fcu_pkg::DP_ERR:
            begin
                res_valid_next     = 1'b1;
                res_next.seg_index = '0;
                res_next.seg_x     = '0;
                res_next.seg_y     = '0;
                res_next.status    = fcu_pkg::STATUS_UNPLACED;
                res_next.last      = 1'b1;
            end
            fcu_pkg::DP_PL_HEAD, fcu_pkg::DP_MV_HEAD:
            begin
                pos_we             = 1'b1;
                prev_x_next        = hx_reg;
                prev_y_next        = hy_reg;
                idx_next           = IW'(1);
                res_valid_next     = 1'b1;
                res_next.seg_index = '0;
                res_next.seg_x     = hx_reg;
                res_next.seg_y     = hy_reg;
                res_next.status    = fcu_pkg::STATUS_OK;
                res_next.last      = seg0_last;
                btx_next           = badj_x[BPW-1:QF];
                bty_next           = badj_y[BPW-1:QF];
                if (cmd.op == fcu_pkg::DP_PL_HEAD)
                begin
                    rad_we      = 1'b1;
                    wr_r        = RADW'(start_radius_reg);
                    prev_r_next = RADW'(start_radius_reg);
                    cur_r_next  = $signed(RADW'(start_radius_reg))
                                - $signed(RADW'(radius_step_reg));
                    count_next  = CW'(1);
                    placed_next = 1'b1;
                end
            end
            fcu_pkg::DP_LOAD_R0:
            begin
                prev_r_next = $signed(rd_r_reg);
            end
            fcu_pkg::DP_DIFF:
            begin
                vx_next    = VW'($signed(rd_x_reg)) - VW'($signed(prev_x_reg));
                vy_next    = VW'($signed(rd_y_reg)) - VW'($signed(prev_y_reg));
                cur_r_next = $signed(rd_r_reg);
            end
            fcu_pkg::DP_SQ:
            begin
                sqx_next = sq_x;
                sqy_next = sq_y;
            end
            fcu_pkg::DP_SUM:
            begin
                sum_next = sqx_reg + sqy_reg;
            end
            fcu_pkg::DP_ZERO:
            begin
                vx_next = '0;
                vy_next = '0;
            end
            fcu_pkg::DP_QUOT:
            begin
                vx_next = vx_reg[VW-1] ? -VW'(quot_x) : VW'(quot_x);
                vy_next = vy_reg[VW-1] ? -VW'(quot_y) : VW'(quot_y);
            end
            fcu_pkg::DP_BIAS:
            begin
                vx_next = vx_reg + VW'(btx_reg);
                vy_next = vy_reg + VW'(bty_reg);
            end
            fcu_pkg::DP_MUL:
            begin
                prod_x_next = PRW'(vx_reg) * PRW'(reach);
                prod_y_next = PRW'(vy_reg) * PRW'(reach);
            end
            fcu_pkg::DP_ADD:
            begin
                pos_we             = 1'b1;
                rad_we             = 1'b1;
                wr_x               = new_x;
                wr_y               = new_y;
                prev_x_next        = new_x;
                prev_y_next        = new_y;
                prev_r_next        = cur_r_reg;
                cur_r_next         = nr;
                idx_next           = idx_reg + IW'(1);
                res_valid_next     = 1'b1;
                res_next.seg_index = fcu_pkg::IDX_W'(idx_reg);
                res_next.seg_x     = new_x;
                res_next.seg_y     = new_y;
                res_next.status    = fcu_pkg::STATUS_OK;
                res_next.last      = seg_last;
                if (op_reg == fcu_pkg::OP_PLACE)
                    count_next = idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_limit_reg     <= 6'd8;
            start_radius_reg  <= 15'd2048;
            radius_step_reg   <= 15'd256;
            follow_mode_reg   <= 1'b0;
            bias_x_reg        <= 16'sd16384;
            bias_y_reg        <= '0;
            bias_strength_reg <= 16'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fcu_pkg::CFG_SEGMENT_LIMIT: seg_limit_reg     <= cfg_data[5:0];
                fcu_pkg::CFG_START_RADIUS:  start_radius_reg  <= cfg_data[14:0];
                fcu_pkg::CFG_RADIUS_STEP:   radius_step_reg   <= cfg_data[14:0];
                fcu_pkg::CFG_FOLLOW_MODE:   follow_mode_reg   <= cfg_data[0];
                fcu_pkg::CFG_BIAS_X:        bias_x_reg        <= cfg_data;
                fcu_pkg::CFG_BIAS_Y:        bias_y_reg        <= cfg_data;
                fcu_pkg::CFG_BIAS_STRENGTH: bias_strength_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            placed_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            placed_reg    <= placed_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hx_reg     <= hx_next;
        hy_reg     <= hy_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        prev_r_reg <= prev_r_next;
        cur_r_reg  <= cur_r_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        sum_reg    <= sum_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        btx_reg    <= btx_next;
        bty_reg    <= bty_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            mem_x[idx_reg] <= wr_x;
            mem_y[idx_reg] <= wr_y;
        end
        if (rad_we)
            mem_r[idx_reg] <= wr_r;
        rd_x_reg <= mem_x[idx_reg];
        rd_y_reg <= mem_y[idx_reg];
        rd_r_reg <= mem_r[idx_reg];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hdl/fcu_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcu_ctrl
// Sequencer for place and move requests, one segment after the other.
// ----------------------------------------------------------------------------
module fcu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fcu_pkg::dp_status_t stat,
    output logic                busy,
    output fcu_pkg::dp_cmd_t    cmd
);

    fcu_pkg::ctrl_state_t state_reg, state_next;
    logic                 pass_reg, pass_next;
    fcu_pkg::ctrl_state_t after_norm;

    assign after_norm = (!pass_reg && stat.follow) ? fcu_pkg::ST_BIAS : fcu_pkg::ST_MUL;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            fcu_pkg::ST_IDLE:
                if (start)
                    state_next = fcu_pkg::ST_DECODE;
            fcu_pkg::ST_DECODE:
                if (stat.is_place)
                    state_next = fcu_pkg::ST_P_HEAD;
                else if (!stat.placed)
                    state_next = fcu_pkg::ST_ERR;
                else
                    state_next = fcu_pkg::ST_M_HEAD;
            fcu_pkg::ST_ERR:
                state_next = fcu_pkg::ST_IDLE;
            fcu_pkg::ST_P_HEAD:
                state_next = stat.seg0_last ? fcu_pkg::ST_IDLE : fcu_pkg::ST_MUL;
            fcu_pkg::ST_M_HEAD:
                state_next = stat.seg0_last ? fcu_pkg::ST_IDLE : fcu_pkg::ST_M_R0;
            fcu_pkg::ST_M_R0:
                state_next = fcu_pkg::ST_DIFF;
            fcu_pkg::ST_DIFF:
            begin
                state_next = fcu_pkg::ST_SQ;
                pass_next  = 1'b0;
            end
            fcu_pkg::ST_SQ:
                state_next = fcu_pkg::ST_SUM;
            fcu_pkg::ST_SUM:
                state_next = fcu_pkg::ST_ROOT_GO;
            fcu_pkg::ST_ROOT_GO:
                state_next = fcu_pkg::ST_ROOT_WAIT;
            fcu_pkg::ST_ROOT_WAIT:
                if (stat.root_done)
                    state_next = stat.root_zero ? after_norm : fcu_pkg::ST_DIV_GO;
            fcu_pkg::ST_DIV_GO:
                state_next = fcu_pkg::ST_DIV_WAIT;
            fcu_pkg::ST_DIV_WAIT:
                if (stat.div_done)
                    state_next = after_norm;
            fcu_pkg::ST_BIAS:
            begin
                state_next = fcu_pkg::ST_SQ;
                pass_next  = 1'b1;
            end
            fcu_pkg::ST_MUL:
                state_next = fcu_pkg::ST_ADD;
            fcu_pkg::ST_ADD:
                if (stat.seg_last)
                    state_next = fcu_pkg::ST_IDLE;
                else if (stat.is_place)
                    state_next = fcu_pkg::ST_MUL;
                else
                    state_next = fcu_pkg::ST_RD;
            fcu_pkg::ST_RD:
                state_next = fcu_pkg::ST_DIFF;
            default:
                state_next = fcu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != fcu_pkg::ST_IDLE);
        cmd.op = fcu_pkg::DP_NOP;
        unique case (state_reg)
            fcu_pkg::ST_IDLE:      if (start) cmd.op = fcu_pkg::DP_LOAD;
            fcu_pkg::ST_ERR:       cmd.op = fcu_pkg::DP_ERR;
            fcu_pkg::ST_P_HEAD:    cmd.op = fcu_pkg::DP_PL_HEAD;
            fcu_pkg::ST_M_HEAD:    cmd.op = fcu_pkg::DP_MV_HEAD;
            fcu_pkg::ST_M_R0:      cmd.op = fcu_pkg::DP_LOAD_R0;
            fcu_pkg::ST_DIFF:      cmd.op = fcu_pkg::DP_DIFF;
            fcu_pkg::ST_SQ:        cmd.op = fcu_pkg::DP_SQ;
            fcu_pkg::ST_SUM:       cmd.op = fcu_pkg::DP_SUM;
            fcu_pkg::ST_ROOT_GO:   cmd.op = fcu_pkg::DP_ROOT_GO;
            fcu_pkg::ST_ROOT_WAIT:
                if (stat.root_done && stat.root_zero)
                    cmd.op = fcu_pkg::DP_ZERO;
            fcu_pkg::ST_DIV_GO:    cmd.op = fcu_pkg::DP_DIV_GO;
            fcu_pkg::ST_DIV_WAIT:  if (stat.div_done) cmd.op = fcu_pkg::DP_QUOT;
            fcu_pkg::ST_BIAS:      cmd.op = fcu_pkg::DP_BIAS;
            fcu_pkg::ST_MUL:       cmd.op = fcu_pkg::DP_MUL;
            fcu_pkg::ST_ADD:       cmd.op = fcu_pkg::DP_ADD;
            default:               cmd.op = fcu_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcu_pkg::ST_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

// ===== hdl/follow_chain_update_top.sv =====
// ----------------------------------------------------------------------------
// follow_chain_update_top
// Chain of circle segments placed from a head point or pulled after it.
// Place: the head result first, then each further segment from a multiply and an add step.
// Move: each segment is normalized with a 25-step square root and a 15-step divide,
//   and is normalized twice in tentacle mode.
// One request at a time; busy drops in the cycle the last result is strobed.
// Results are single-cycle strobes and cannot be stalled.
// Reset clears configuration to defaults and forgets the placed chain.
// ----------------------------------------------------------------------------
module follow_chain_update_top #(
    parameter int MAX_SEGMENTS = fcu_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  fcu_pkg::in_item_t         item,
    output logic                      result_valid,
    output fcu_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [fcu_pkg::CFG_W-1:0] cfg_data
);

    fcu_pkg::dp_cmd_t    cmd;
    fcu_pkg::dp_status_t stat;

    fcu_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .busy (busy),
        .cmd  (cmd)
    );

    fcu_datapath #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item),
        .cmd         (cmd),
        .stat        (stat),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule
